// ===== hdl/bitmap_first_last_bit_search_assert.svh =====
// ----------------------------------------------------------------------------
// Assertion macros for the bitmap first/last bit search block.
// ----------------------------------------------------------------------------
`ifndef BITMAP_FIRST_LAST_BIT_SEARCH_ASSERT_SVH
`define BITMAP_FIRST_LAST_BIT_SEARCH_ASSERT_SVH

// Same-cycle implication, checked at every rising edge outside reset.
`define BFL_ASSERT_IMP(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked at every rising edge outside reset.
`define BFL_ASSERT_NXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== hdl/bfl_pkg.sv =====
// ----------------------------------------------------------------------------
// bfl_pkg
// Shared sizes, action codes and the search beat type of the bitmap
// first/last bit search.
// ----------------------------------------------------------------------------
`default_nettype none

package bfl_pkg;

  // Bitmap geometry.
  localparam int NUM_WORDS  = 16;
  localparam int WORD_BITS  = 64;
  localparam int TOTAL_BITS = NUM_WORDS * WORD_BITS;

  // Port widths fixed by the interface.
  localparam int ACT_W   = 3;
  localparam int WIDX_W  = 4;
  localparam int DATA_W  = 64;
  localparam int COUNT_W = 11;
  localparam int POS_W   = 11;

  // Internal widths: counts and positions, and a bit index inside one word.
  localparam int CNT_W = ($clog2(TOTAL_BITS + 1) > COUNT_W) ?
                         $clog2(TOTAL_BITS + 1) : COUNT_W;
  localparam int BIT_W = $clog2(WORD_BITS);

  // Action codes.
  localparam logic [ACT_W-1:0] ACT_WRITE      = 3'd0;
  localparam logic [ACT_W-1:0] ACT_FIRST_SET  = 3'd1;
  localparam logic [ACT_W-1:0] ACT_FIRST_ZERO = 3'd2;
  localparam logic [ACT_W-1:0] ACT_LAST_SET   = 3'd3;
  localparam logic [ACT_W-1:0] ACT_LAST_ZERO  = 3'd4;

  // Search beat handed from cell to cell.
  typedef struct packed {
    logic             vld;   // a query is in this stage
    logic             want;  // bit value searched for
    logic             up;    // lowest position wanted
    logic [CNT_W-1:0] cnt;   // saturated bit count
    logic [CNT_W-1:0] base;  // position of bit 0 of the next word
    logic             hit;   // a match has been seen
    logic [CNT_W-1:0] pos;   // position of the match kept so far
  } tok_t;

endpackage

`default_nettype wire

// ===== hdl/bfl_cell.sv =====
// ----------------------------------------------------------------------------
// bfl_cell
// One bitmap word with its search stage: folds the word into the passing
// search beat and registers the beat for the next cell.
// ----------------------------------------------------------------------------
`default_nettype none

module bfl_cell (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          wr_en,
  input  logic [bfl_pkg::WORD_BITS-1:0] wr_data,
  input  bfl_pkg::tok_t                 tok_in,
  output bfl_pkg::tok_t                 tok_out
);
  import bfl_pkg::*;

  logic [WORD_BITS-1:0] word;
  logic [WORD_BITS-1:0] mask;
  logic [WORD_BITS-1:0] cand;
  logic [CNT_W-1:0]     rem;
  logic                 any;
  logic [BIT_W-1:0]     lo;
  logic [BIT_W-1:0]     hi;
  tok_t                 tok_next;

  // Stored word, all zero after reset.
  always_ff @(posedge clk) begin
    if (rst) begin
      word <= '0;
    end else if (wr_en) begin
      word <= wr_data;
    end
  end

  // Bits of this word that lie below the count.
  always_comb begin
    rem = (tok_in.cnt > tok_in.base) ? (tok_in.cnt - tok_in.base) : '0;
    for (int b = 0; b < WORD_BITS; b++) begin
      mask[b] = (CNT_W'(b) < rem);
    end
    cand = (tok_in.want ? word : ~word) & mask;
    any  = |cand;
  end

  // Lowest and highest matching bit of this word.
  always_comb begin
    lo = '0;
    for (int b = WORD_BITS - 1; b >= 0; b--) begin
      if (cand[b]) lo = BIT_W'(b);
    end
    hi = '0;
    for (int b = 0; b < WORD_BITS; b++) begin
      if (cand[b]) hi = BIT_W'(b);
    end
  end

  // Words pass in rising order: an upward search keeps its first match,
  // a downward search lets every later match replace the one it holds.
  always_comb begin
    tok_next      = tok_in;
    tok_next.base = tok_in.base + CNT_W'(WORD_BITS);
    if (tok_in.up) begin
      if (!tok_in.hit && any) begin
        tok_next.hit = 1'b1;
        tok_next.pos = tok_in.base + CNT_W'(lo);
      end
    end else if (any) begin
      tok_next.hit = 1'b1;
      tok_next.pos = tok_in.base + CNT_W'(hi);
    end
  end

  // Beat register toward the next cell.
  always_ff @(posedge clk) begin
    if (rst) begin
      tok_out <= '0;
    end else begin
      tok_out <= tok_next;
    end
  end

endmodule

`default_nettype wire

// ===== hdl/bitmap_first_last_bit_search.sv =====
// ----------------------------------------------------------------------------
// bitmap_first_last_bit_search
// Bitmap of 16 words of 64 bits with first/last set/clear bit queries.
// ----------------------------------------------------------------------------
// Usage:
//   An item is taken at a rising edge with start high and busy low. Action
//   write stores word_data into word word_index and gives no result; a write
//   to a word beyond the bitmap and the unused action codes do nothing.
//   The four query actions search the positions below bit_count (saturated
//   to the bitmap size) for the lowest or highest set or clear bit.
//   A query runs through a row of 16 cells, one word per cell, one cell
//   per cycle. Its result is shown on position and found with done high
//   for one cycle, out of the beat register of the last cell. No match,
//   or a zero count, gives position -1, found low. busy is high while a
//   query is in the first 15 cells, so a new query is not taken until the
//   last one reaches the last cell; a write leaves busy low. The receiver
//   cannot stall a result. Reset clears the bitmap and drops any query in
//   flight; busy stays high while reset is held.
// ----------------------------------------------------------------------------
`default_nettype none

module bitmap_first_last_bit_search (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               start,
  output logic                               busy,
  input  logic [bfl_pkg::ACT_W-1:0]          action,
  input  logic [bfl_pkg::WIDX_W-1:0]         word_index,
  input  logic [bfl_pkg::DATA_W-1:0]         word_data,
  input  logic [bfl_pkg::COUNT_W-1:0]        bit_count,
  output logic                               done,
  output logic signed [bfl_pkg::POS_W-1:0]   position,
  output logic                               found
);
  import bfl_pkg::*;

  localparam int WI_W = ($clog2(NUM_WORDS) > WIDX_W) ? $clog2(NUM_WORDS) : WIDX_W;
  localparam logic [NUM_WORDS-1:0] MID_MASK = {NUM_WORDS{1'b1}} >> 1;
  localparam logic [CNT_W-1:0]     TOTAL    = CNT_W'(TOTAL_BITS);

  logic                 accept;
  logic                 wr_acc;
  logic                 is_query;
  logic [CNT_W-1:0]     cnt_ext;
  logic [NUM_WORDS-1:0] vld;
  tok_t                 launch;
  tok_t                 chain [NUM_WORDS+1];

  // Handshake and action decode.
  assign accept   = start && !busy;
  assign wr_acc   = accept && (action == ACT_WRITE);
  assign is_query = (action == ACT_FIRST_SET) || (action == ACT_FIRST_ZERO) ||
                    (action == ACT_LAST_SET)  || (action == ACT_LAST_ZERO);

  // Search beat entering the first cell.
  always_comb begin
    cnt_ext     = CNT_W'(bit_count);
    launch      = '0;
    launch.vld  = accept && is_query;
    launch.want = (action == ACT_FIRST_SET) || (action == ACT_LAST_SET);
    launch.up   = (action == ACT_FIRST_SET) || (action == ACT_FIRST_ZERO);
    launch.cnt  = (cnt_ext > TOTAL) ? TOTAL : cnt_ext;
  end

  assign chain[0] = launch;

  // Row of cells, word i in cell i.
  for (genvar i = 0; i < NUM_WORDS; i++) begin : g_cell
    logic wr_en;
    assign wr_en  = wr_acc && (WI_W'(word_index) == WI_W'(i));
    assign vld[i] = chain[i+1].vld;

    bfl_cell u_cell (
      .clk     (clk),
      .rst     (rst),
      .wr_en   (wr_en),
      .wr_data (word_data[WORD_BITS-1:0]),
      .tok_in  (chain[i]),
      .tok_out (chain[i+1])
    );
  end

  // Busy until the query reaches the last cell.
  assign busy = rst || (|(vld & MID_MASK));

  // Result beat from the last cell.
  assign done     = chain[NUM_WORDS].vld;
  assign found    = chain[NUM_WORDS].hit;
  assign position = chain[NUM_WORDS].hit ? $signed(chain[NUM_WORDS].pos[POS_W-1:0]) :
                                           $signed({POS_W{1'b1}});

endmodule

`default_nettype wire

// ===== hdl/bfl_checker.sv =====
// ----------------------------------------------------------------------------
// bfl_checker
// Port-level checks of the bitmap first/last bit search, bound to the top.
// ----------------------------------------------------------------------------
`default_nettype none

`include "bitmap_first_last_bit_search_assert.svh"

module bfl_checker (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               start,
  input  logic                               busy,
  input  logic [bfl_pkg::ACT_W-1:0]          action,
  input  logic [bfl_pkg::COUNT_W-1:0]        bit_count,
  input  logic                               done,
  input  logic signed [bfl_pkg::POS_W-1:0]   position,
  input  logic                               found
);
  import bfl_pkg::*;

  logic q_acc;
  logic q_zero;
  logic w_acc;

  // A query beat taken at this edge.
  assign q_acc = start && !busy &&
                 ((action == ACT_FIRST_SET) || (action == ACT_FIRST_ZERO) ||
                  (action == ACT_LAST_SET)  || (action == ACT_LAST_ZERO));

  // A query beat with a zero count, and a write beat taken while idle.
  assign q_zero = q_acc && (bit_count == '0);
  assign w_acc  = start && !busy && (action == ACT_WRITE) && !done;

  // Every query gives its result after a fixed trip through the row.
  `BFL_ASSERT_IMP(a_query_latency, clk, rst, q_acc, ##NUM_WORDS done, "query result missing")

  // A zero count never finds anything.
  `BFL_ASSERT_IMP(a_zero_count, clk, rst, q_zero, ##NUM_WORDS (done && !found), "zero count hit")

  // A miss reports position -1.
  `BFL_ASSERT_IMP(a_miss_pos, clk, rst, done && !found, &position, "miss without position -1")

  // An idle block takes a write and stays free for the next beat.
  `BFL_ASSERT_NXT(a_write_free, clk, rst, w_acc, !busy || done, "write left block busy")

endmodule

bind bitmap_first_last_bit_search bfl_checker u_bfl_checker (.*);

`default_nettype wire

// ===== tb/bitmap_first_last_bit_search_checker.sv =====
// ----------------------------------------------------------------------------
// bitmap_first_last_bit_search_checker
// Watches the command and result ports of the bitmap search block. It keeps
// its own copy of the bitmap and works out every query answer when the
// query beat is taken. Each result beat is then compared with the oldest
// answer still due.
// ----------------------------------------------------------------------------

module bitmap_first_last_bit_search_checker (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                start,
  input  logic                                busy,
  input  logic [bfl_pkg::ACT_W-1:0]           action,
  input  logic [bfl_pkg::WIDX_W-1:0]          word_index,
  input  logic [bfl_pkg::DATA_W-1:0]          word_data,
  input  logic [bfl_pkg::COUNT_W-1:0]         bit_count,
  input  logic                                done,
  input  logic signed [bfl_pkg::POS_W-1:0]    position,
  input  logic                                found,
  output int                                  mismatch_count,
  output int                                  results_due
);

  timeunit 1ns;
  timeprecision 1ps;

  import bfl_pkg::*;

  localparam int REPORT_LIMIT = 10;

  // One query answer.
  typedef struct packed {
    logic signed [POS_W-1:0] position;
    logic                    found;
  } search_answer_t;

  logic [WORD_BITS-1:0] bitmap_mirror [NUM_WORDS];
  search_answer_t       answers_due [$];
  int                   errors;

  // Scan the mirrored bitmap the way the query asks, below the saturated count.
  function automatic search_answer_t scan_bitmap(input logic [ACT_W-1:0] op,
                                                 input logic [COUNT_W-1:0] count_in);
    int             span;
    int             p;
    logic           want;
    logic           upward;
    search_answer_t ans;
    span = int'(count_in);
    if (span > TOTAL_BITS) span = TOTAL_BITS;
    want   = (op == ACT_FIRST_SET) || (op == ACT_LAST_SET);
    upward = (op == ACT_FIRST_SET) || (op == ACT_FIRST_ZERO);
    ans.position = '1;
    ans.found    = 1'b0;
    for (int k = 0; k < span; k++) begin
      p = upward ? k : (span - 1 - k);
      if (bitmap_mirror[p / WORD_BITS][p % WORD_BITS] == want) begin
        ans.position = POS_W'(p);
        ans.found    = 1'b1;
        break;
      end
    end
    return ans;
  endfunction

  initial begin
    errors = 0;
    foreach (bitmap_mirror[i]) bitmap_mirror[i] = '0;
  end

  // Sample both channels at the rising edge. The result is retired before a
  // new query is queued, since both may happen at the same edge.
  always @(posedge clk) begin
    search_answer_t want_ans;
    if (rst) begin
      foreach (bitmap_mirror[i]) bitmap_mirror[i] = '0;
      answers_due.delete();
    end else begin
      // Result beat.
      if (done) begin
        if (answers_due.size() == 0) begin
          if (errors < REPORT_LIMIT)
            $display("%0t: result with nothing due: position %0d found %0b",
                     $realtime, position, found);
          errors++;
        end else begin
          want_ans = answers_due.pop_front();
          if (position !== want_ans.position || found !== want_ans.found) begin
            if (errors < REPORT_LIMIT)
              $display("%0t: expected position %0d found %0b, got position %0d found %0b",
                       $realtime, want_ans.position, want_ans.found, position, found);
            errors++;
          end
        end
      end
      // Command beat.
      if (start && !busy) begin
        if (action == ACT_WRITE) begin
          if (int'(word_index) < NUM_WORDS)
            bitmap_mirror[word_index] = word_data[WORD_BITS-1:0];
        end else if (action <= ACT_LAST_ZERO) begin
          answers_due.push_back(scan_bitmap(action, bit_count));
        end
      end
    end
    mismatch_count <= errors;
    results_due    <= answers_due.size();
  end

endmodule

// ===== tb/bitmap_first_last_bit_search_tb.sv =====
// ----------------------------------------------------------------------------
// bitmap_first_last_bit_search_tb
// Drives write and query beats into the bitmap search block: a directed
// opening over the corner cases, then random traffic with random gaps. A
// checker beside the block predicts and compares; this module gives the
// verdict once every answer has arrived.
// ----------------------------------------------------------------------------

module bitmap_first_last_bit_search_tb;

  timeunit 1ns;
  timeprecision 1ps;

  import bfl_pkg::*;

  // Action codes that the block ignores.
  localparam logic [ACT_W-1:0] ACT_RESERVED_FIRST = 3'd5;
  localparam logic [ACT_W-1:0] ACT_RESERVED_LAST  = 3'd7;

  localparam int RANDOM_BEATS = 500;
  localparam int QUERY_CYCLES = 16;
  localparam int DRAIN_LIMIT  = 4000;
  localparam int WATCHDOG_NS  = 6_000_000;

  logic                    clk;
  logic                    rst;
  logic                    start;
  logic                    busy;
  logic [ACT_W-1:0]        action;
  logic [WIDX_W-1:0]       word_index;
  logic [DATA_W-1:0]       word_data;
  logic [COUNT_W-1:0]      bit_count;
  logic                    done;
  logic signed [POS_W-1:0] position;
  logic                    found;
  int                      mismatch_count;
  int                      results_due;

  bit                      quiet_stretch;

  bitmap_first_last_bit_search DUT (
    .clk        (clk),
    .rst        (rst),
    .start      (start),
    .busy       (busy),
    .action     (action),
    .word_index (word_index),
    .word_data  (word_data),
    .bit_count  (bit_count),
    .done       (done),
    .position   (position),
    .found      (found)
  );

  bitmap_first_last_bit_search_checker u_checker (
    .clk            (clk),
    .rst            (rst),
    .start          (start),
    .busy           (busy),
    .action         (action),
    .word_index     (word_index),
    .word_data      (word_data),
    .bit_count      (bit_count),
    .done           (done),
    .position       (position),
    .found          (found),
    .mismatch_count (mismatch_count),
    .results_due    (results_due)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Hard stop in case the block hangs.
  initial begin
    #(WATCHDOG_NS);
    $display("[bitmap_first_last_bit_search] ERROR");
    $finish;
  end

  // Offer one beat from a falling edge, hold it until taken, then idle for a random gap that may be zero.
  task automatic send_beat(input logic [ACT_W-1:0]   op,
                           input logic [WIDX_W-1:0]  idx,
                           input logic [DATA_W-1:0]  data,
                           input logic [COUNT_W-1:0] count);
    int gap;
    int roll;
    start      <= 1'b1;
    action     <= op;
    word_index <= idx;
    word_data  <= data;
    bit_count  <= count;
    do @(posedge clk); while (busy);
    @(negedge clk);
    // Mostly no gap or a short one, sometimes long enough to span a query.
    roll = $urandom_range(0, 99);
    if (quiet_stretch || roll < 50) gap = 0;
    else if (roll < 85) gap = $urandom_range(1, 4);
    else if (roll < 95) gap = $urandom_range(5, 18);
    else gap = $urandom_range(20, 60);
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(negedge clk);
    end
  endtask

  initial begin
    logic [ACT_W-1:0]   op;
    logic [DATA_W-1:0]  data;
    logic [COUNT_W-1:0] count;
    int                 roll;
    int                 waited;

    quiet_stretch = 1'b0;
    rst        = 1'b1;
    start      = 1'b0;
    action     = ACT_WRITE;
    word_index = '0;
    word_data  = '0;
    bit_count  = '0;
    repeat (8) @(negedge clk);
    rst <= 1'b0;

    // Cleared bitmap, full and saturated counts, zero counts.
    send_beat(ACT_FIRST_SET,  4'd3,  '1, 11'd1024);
    send_beat(ACT_FIRST_ZERO, 4'd0,  '0, 11'd1024);
    send_beat(ACT_LAST_SET,   4'd9,  '0, 11'd2047);
    send_beat(ACT_LAST_ZERO,  4'd15, '1, 11'd2047);
    send_beat(ACT_LAST_ZERO,  4'd0,  '0, 11'd0);
    send_beat(ACT_FIRST_ZERO, 4'd15, '1, 11'd0);

    // Both end words fully set.
    send_beat(ACT_WRITE, 4'd0,  '1, 11'd2047);
    send_beat(ACT_WRITE, 4'd15, '1, 11'd0);
    send_beat(ACT_FIRST_ZERO, 4'd0, '0, 11'd1024);
    send_beat(ACT_LAST_SET,   4'd0, '0, 11'd1024);
    send_beat(ACT_LAST_SET,   4'd0, '0, 11'd1000);
    send_beat(ACT_FIRST_SET,  4'd0, '0, 11'd1);
    send_beat(ACT_LAST_ZERO,  4'd0, '0, 11'd64);
    send_beat(ACT_FIRST_SET,  4'd0, '0, 11'd0);

    // Edge bits of a middle word.
    send_beat(ACT_WRITE, 4'd7, 64'h8000_0000_0000_0001, 11'd5);
    send_beat(ACT_LAST_ZERO, 4'd0, '0, 11'd1024);

    // Unused action codes change nothing.
    for (int a = ACT_RESERVED_FIRST; a <= ACT_RESERVED_LAST; a++)
      send_beat(ACT_W'(a), 4'($urandom), {$urandom, $urandom}, 11'($urandom));

    // Only the middle word left.
    send_beat(ACT_WRITE, 4'd0,  '0, 11'd7);
    send_beat(ACT_WRITE, 4'd15, '0, 11'd7);
    send_beat(ACT_FIRST_SET, 4'd0, '0, 11'd1024);
    send_beat(ACT_LAST_SET,  4'd0, '0, 11'd1024);
    send_beat(ACT_FIRST_SET, 4'd0, '0, 11'd448);
    send_beat(ACT_FIRST_SET, 4'd0, '0, 11'd449);
    send_beat(ACT_WRITE, 4'd7, '0, 11'd0);

    // Random traffic. Sparse and uniform words keep searches running deep.
    for (int n = 0; n < RANDOM_BEATS; n++) begin
      if (n % 60 == 0) quiet_stretch = ($urandom_range(0, 2) == 0);
      roll = $urandom_range(0, 99);
      if (roll < 35) op = ACT_WRITE;
      else if (roll < 95) op = ACT_W'($urandom_range(ACT_FIRST_SET, ACT_LAST_ZERO));
      else op = ACT_W'($urandom_range(ACT_RESERVED_FIRST, ACT_RESERVED_LAST));

      case ($urandom_range(0, 7))
        0:       data = '0;
        1:       data = '1;
        2:       data = 64'd1 << $urandom_range(0, 63);
        3:       data = ~(64'd1 << $urandom_range(0, 63));
        4:       data = {$urandom, $urandom} & {$urandom, $urandom} & {$urandom, $urandom};
        default: data = {$urandom, $urandom};
      endcase

      case ($urandom_range(0, 9))
        0:       count = '0;
        1:       count = 11'($urandom_range(TOTAL_BITS + 1, 2047));
        2, 3:    count = 11'(WORD_BITS * $urandom_range(1, NUM_WORDS) - 1 + $urandom_range(0, 2));
        default: count = 11'($urandom_range(1, TOTAL_BITS));
      endcase

      send_beat(op, 4'($urandom), data, count);
    end
    start <= 1'b0;

    // Drain the answers still in flight, then let the pipeline settle.
    waited = 0;
    while (results_due != 0 && waited < DRAIN_LIMIT) begin
      @(negedge clk);
      waited++;
    end
    repeat (QUERY_CYCLES + 4) @(negedge clk);

    if (mismatch_count == 0 && results_due == 0) begin
      $display("[bitmap_first_last_bit_search] OK");
    end else begin
      $display("[bitmap_first_last_bit_search] ERROR");
    end
    $finish;
  end

endmodule
